// ===== design/upq_pkg.sv =====
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types, codes and defaults for the unsorted priority queue.
// ----------------------------------------------------------------------------
package upq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int PRIO_W = 32;
  localparam int WORD_W = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic            cap;        // capture input item
    logic            set_st;     // load status, zero the result fields
    logic [ST_W-1:0] st;
    logic            ins;        // append request entry
    logic            clr;        // empty the store
    logic            scan_init;  // point at newest entry, arm first compare
    logic            scan_rd;    // read entry, step pointer down
    logic            sh_init;    // point just above the removed entry
    logic            sh_rd;      // read entry, step pointer up (write uses the registered read)
    logic            dec;        // count down after remove
    logic            out_load;   // load the output register
  } upq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            idx_zero;
    logic            idx_last;
    logic            best_last;
  } upq_sts_t;

endpackage

// ===== design/upq_if.sv =====
// ----------------------------------------------------------------------------
// upq_in_if / upq_out_if
// Valid/ready channels for requests and results of the priority queue.
// ----------------------------------------------------------------------------
interface upq_in_if;
  logic                         valid;
  logic                         ready;
  logic [upq_pkg::OP_W-1:0]     opcode;
  logic signed [upq_pkg::PRIO_W-1:0] priority_req;
  logic [upq_pkg::WORD_W-1:0]   payload;

  modport source (output valid, opcode, priority_req, payload, input ready);
  modport sink   (input valid, opcode, priority_req, payload, output ready);
endinterface

interface upq_out_if #(
  parameter int OCC_W = 5
);
  logic                         valid;
  logic                         ready;
  logic [upq_pkg::ST_W-1:0]     status;
  logic signed [upq_pkg::PRIO_W-1:0] out_priority;
  logic [upq_pkg::WORD_W-1:0]   out_payload;
  logic [OCC_W-1:0]             occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy,
                  input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy,
                  output ready);
endinterface

// ===== design/upq_datapath.sv =====
// ----------------------------------------------------------------------------
// upq_datapath
// Entry store, scan compare, shift-down copy and result/output registers.
// ----------------------------------------------------------------------------
module upq_datapath #(
  parameter int DEPTH         = upq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = upq_pkg::PAYLOAD_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  upq_pkg::upq_cmd_t               cmd_i,
  output upq_pkg::upq_sts_t               sts_o,
  input  logic [upq_pkg::OP_W-1:0]        opcode_i,
  input  logic [upq_pkg::PRIO_W-1:0]      prio_i,
  input  logic [upq_pkg::WORD_W-1:0]      payload_i,
  output logic [upq_pkg::ST_W-1:0]        status_o,
  output logic [upq_pkg::PRIO_W-1:0]      out_prio_o,
  output logic [upq_pkg::WORD_W-1:0]      out_payload_o,
  output logic [CW-1:0]                   occupancy_o
);

  logic [upq_pkg::PRIO_W-1:0] prio_mem [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]   pay_mem  [DEPTH];

  logic [upq_pkg::OP_W-1:0]   op_q;
  logic [upq_pkg::PRIO_W-1:0] req_prio_q;
  logic [PAYLOAD_WIDTH-1:0]   req_pay_q;
  logic [CW-1:0]              cnt_q;
  logic [AW-1:0]              idx_q;
  logic [AW-1:0]              rd_idx_q;
  logic [upq_pkg::PRIO_W-1:0] rd_prio_q;
  logic [PAYLOAD_WIDTH-1:0]   rd_pay_q;
  logic                       rd_scan_q;
  logic                       rd_shift_q;
  logic                       first_q;
  logic [AW-1:0]              best_q;
  logic [upq_pkg::PRIO_W-1:0] best_prio_q;
  logic [PAYLOAD_WIDTH-1:0]   best_pay_q;
  logic [upq_pkg::ST_W-1:0]   status_q;

  logic [upq_pkg::ST_W-1:0]   out_status_q;
  logic [upq_pkg::PRIO_W-1:0] out_prio_q;
  logic [upq_pkg::WORD_W-1:0] out_pay_q;
  logic [CW-1:0]              out_occ_q;

  logic                       rd_en;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [upq_pkg::PRIO_W-1:0] wr_prio;
  logic [PAYLOAD_WIDTH-1:0]   wr_pay;
  logic                       take;

  assign rd_en   = cmd_i.scan_rd | cmd_i.sh_rd;
  assign wr_en   = cmd_i.ins | rd_shift_q;
  // shift copies entry i+1 down into slot i
  assign wr_addr = cmd_i.ins ? cnt_q[AW-1:0] : rd_idx_q - AW'(1);
  assign wr_prio = cmd_i.ins ? req_prio_q : rd_prio_q;
  assign wr_pay  = cmd_i.ins ? req_pay_q  : rd_pay_q;

  // strict compare while scanning newest to oldest keeps the newest on ties
  assign take = rd_scan_q && (first_q || ($signed(rd_prio_q) < $signed(best_prio_q)));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
      pay_mem[wr_addr]  <= wr_pay;
    end
    if (rd_en) begin
      rd_prio_q <= prio_mem[idx_q];
      rd_pay_q  <= pay_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_scan_q  <= 1'b0;
      rd_shift_q <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      rd_scan_q  <= cmd_i.scan_rd;
      rd_shift_q <= cmd_i.sh_rd;
      if (cmd_i.scan_init) begin
        first_q <= 1'b1;
      end else if (rd_scan_q) begin
        first_q <= 1'b0;
      end
      if (cmd_i.clr) begin
        cnt_q <= '0;
      end else if (cmd_i.ins) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q       <= opcode_i;
      req_prio_q <= prio_i;
      req_pay_q  <= PAYLOAD_WIDTH'(payload_i);
    end
    if (cmd_i.scan_init) begin
      idx_q <= AW'(cnt_q - CW'(1));
    end else if (cmd_i.scan_rd) begin
      idx_q <= idx_q - AW'(1);
    end else if (cmd_i.sh_init) begin
      idx_q <= best_q + AW'(1);
    end else if (cmd_i.sh_rd) begin
      idx_q <= idx_q + AW'(1);
    end
    if (rd_en) begin
      rd_idx_q <= idx_q;
    end
    if (cmd_i.set_st) begin
      status_q    <= cmd_i.st;
      best_prio_q <= '0;
      best_pay_q  <= '0;
    end else if (take) begin
      best_q      <= rd_idx_q;
      best_prio_q <= rd_prio_q;
      best_pay_q  <= rd_pay_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_prio_q   <= best_prio_q;
      out_pay_q    <= upq_pkg::WORD_W'(best_pay_q);
      out_occ_q    <= cnt_q;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.full      = (cnt_q == CW'(DEPTH));
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.idx_last  = (CW'(idx_q) == cnt_q - CW'(1));
  assign sts_o.best_last = (CW'(best_q) == cnt_q - CW'(1));

  assign status_o      = out_status_q;
  assign out_prio_o    = out_prio_q;
  assign out_payload_o = out_pay_q;
  assign occupancy_o   = out_occ_q;

endmodule

// ===== design/upq_ctrl.sv =====
// ----------------------------------------------------------------------------
// upq_ctrl
// Sequencer: decodes an item, runs scan and shift passes, hands off result.
// ----------------------------------------------------------------------------
module upq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output upq_pkg::upq_cmd_t cmd_o,
  input  upq_pkg::upq_sts_t sts_i
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DEC     = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_SCAN_END = 3'd3;
  localparam logic [2:0] S_SH_INIT = 3'd4;
  localparam logic [2:0] S_SHIFT   = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st = upq_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.set_st = 1'b1;
        state_d      = S_RESP;
        case (sts_i.op)
          upq_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.st = upq_pkg::ST_FULL;
            end else begin
              cmd_o.ins = 1'b1;
            end
          end
          upq_pkg::OP_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.st = upq_pkg::ST_EMPTY;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          upq_pkg::OP_CLEAR: begin
            cmd_o.clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_zero) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last compare lands this cycle
        state_d = S_SH_INIT;
      end
      S_SH_INIT: begin
        if (sts_i.best_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.sh_init = 1'b1;
          state_d       = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.sh_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // trailing shift write completes here
        cmd_o.dec = 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/unsorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// unsorted_priority_queue_unit
// Priority queue over an unsorted entry store with linear remove-min scan.
// ----------------------------------------------------------------------------
//
//  channel  dir  item fields
//  -------  ---  ------------------------------------------------------
//  in_i     in   opcode, priority_req, payload
//  out_o    out  status, out_priority, out_payload, occupancy
//
//  Insert, clear, a dropped insert, an empty remove and an unused opcode go
//  straight from decode to the output load. Remove-min scans the N entries
//  held, then closes the gap above the removed slot k (one store read per
//  cycle). The next item can be accepted in the cycle after the load.
//  A result waits in the output register while the next item runs, which only
//  stalls at its end if that register is still full. Reset clears count and
//  control; the store is not cleared (only entries below the count are read).
//
module unsorted_priority_queue_unit #(
  parameter int DEPTH         = upq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = upq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upq_in_if.sink    in_i,
  upq_out_if.source out_o
);

  localparam int CW = $clog2(DEPTH + 1);

  upq_pkg::upq_cmd_t cmd;
  upq_pkg::upq_sts_t sts;
  logic [CW-1:0]     occupancy;

  upq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  upq_datapath #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_i.opcode),
    .prio_i        (in_i.priority_req),
    .payload_i     (in_i.payload),
    .status_o      (out_o.status),
    .out_prio_o    (out_o.out_priority),
    .out_payload_o (out_o.out_payload),
    .occupancy_o   (occupancy)
  );

  assign out_o.occupancy = occupancy;

  // a dropped insert only happens with the store at capacity
  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == upq_pkg::ST_FULL) |-> occupancy == CW'(DEPTH))
    else $error("full status with occupancy below depth");

  // an empty remove returns zero fields and an empty store
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == upq_pkg::ST_EMPTY) |->
      (out_o.out_priority == '0 && out_o.out_payload == '0 && occupancy == '0))
    else $error("empty status with nonzero result");

  // one item in work at a time
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("accepted an item while busy");

  // count never passes capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> occupancy <= CW'(DEPTH))
    else $error("occupancy above depth");

endmodule
